### rtl/spims_pkg.sv
// Shared types and constants of the SPI master message sequencer.
package spims_pkg;

	localparam int TX_DEPTH_DEFAULT = 256;
	localparam int POS_W = 17;

	localparam logic [2:0] KIND_LOAD  = 3'd0;
	localparam logic [2:0] KIND_START = 3'd1;
	localparam logic [2:0] KIND_RX    = 3'd2;
	localparam logic [2:0] KIND_TXE   = 3'd3;
	localparam logic [2:0] KIND_ERROR = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  tx_index;
		logic [7:0]  tx_byte;
		logic [8:0]  tx_length;
		logic [15:0] skip_count;
		logic [15:0] take_count;
		logic        assert_select;
		logic        release_select;
		logic [7:0]  rx_byte;
	} cmd_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_data;
		logic        rx_valid;
		logic [15:0] rx_offset;
		logic [7:0]  rx_data;
		logic [15:0] transferred_count;
		logic        message_done;
		logic        select_active;
		logic        busy_res;
	} rsp_t;

endpackage

### rtl/spims_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module spims_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = spims_pkg::TX_DEPTH_DEFAULT,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/spi_master_message_sequencer.sv
// Top level of the SPI master message sequencer.
// The block takes one item per clock cycle while the output side does not stall, and returns
// exactly one result per item. The registered read of the transmit buffer RAM and the
// stage-one register are both loaded when an item is accepted, and the output register is
// loaded from them when stage one advances. While a result waits at the output,
// one more item can be accepted into stage one, and then the input stalls until the output
// moves. Message cursors, lengths and chip-select state live in registers updated at
// acceptance; transmit bytes live in a TX_DEPTH-entry RAM that is written by load items and
// read on transmit-empty items.
module spi_master_message_sequencer #(
	parameter int TX_DEPTH = spims_pkg::TX_DEPTH_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  spims_pkg::cmd_t cmd,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output spims_pkg::rsp_t rsp
);

	localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam int PW = spims_pkg::POS_W;
	localparam logic [PW-1:0] DEPTH_W = PW'(TX_DEPTH);

	logic [PW-1:0] rx_pos_q, tx_pos_q, len_q;
	logic [15:0]   skip_q, take_q;
	logic [8:0]    tl_q;
	logic          rel_q, sel_q, busy_q, done_q;

	logic [PW-1:0] rx_pos_d, tx_pos_d, len_d;
	logic [15:0]   skip_d, take_d;
	logic [8:0]    tl_d;
	logic          rel_d, sel_d, busy_d, done_d;

	logic            accept;
	logic            we, re;
	logic [AW-1:0]   waddr, raddr;
	logic [7:0]      rdata;
	logic [AW-1:0]   wrap_idx [256];
	logic [PW-1:0]   tl_clamp;
	logic [PW-1:0]   rx_total;
	logic [PW-1:0]   new_len;
	logic [PW-1:0]   off;
	logic [PW-1:0]   rx_inc;
	logic [PW-1:0]   tidx;
	logic [PW-1:0]   xfer;
	spims_pkg::rsp_t res;

	logic            v_s1;
	logic            mem_s1;
	spims_pkg::rsp_t res_s1;
	spims_pkg::rsp_t res_out;
	logic            rsp_valid_q;
	spims_pkg::rsp_t rsp_q;
	logic            adv;

	assign accept = cmd_valid && cmd_ready;
	assign adv = v_s1 && (!rsp_valid_q || rsp_ready);
	assign cmd_ready = !v_s1 || adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	for (genvar g = 0; g < 256; g++) begin : g_wrap
		assign wrap_idx[g] = AW'(g % TX_DEPTH);
	end

	assign waddr = wrap_idx[cmd.tx_index];

	always_comb begin
		tl_clamp = (PW'(cmd.tx_length) > DEPTH_W) ? DEPTH_W : PW'(cmd.tx_length);
		rx_total = PW'(cmd.skip_count) + PW'(cmd.take_count);
		new_len = (tl_clamp > rx_total) ? tl_clamp : rx_total;
		off = rx_pos_q - PW'(skip_q);
		rx_inc = rx_pos_q + PW'(1);
		tidx = (tx_pos_q < PW'(tl_q)) ? tx_pos_q : PW'(tl_q) - PW'(1);
		raddr = tidx[AW-1:0];

		rx_pos_d = rx_pos_q;
		tx_pos_d = tx_pos_q;
		len_d = len_q;
		skip_d = skip_q;
		take_d = take_q;
		tl_d = tl_q;
		rel_d = rel_q;
		sel_d = sel_q;
		busy_d = busy_q;
		done_d = done_q;
		we = 1'b0;
		re = 1'b0;
		res = '0;

		unique case (cmd.kind)
			spims_pkg::KIND_LOAD: begin
				we = accept;
			end
			spims_pkg::KIND_START: begin
				if (!busy_q) begin
					tl_d = tl_clamp[8:0];
					skip_d = cmd.skip_count;
					take_d = cmd.take_count;
					rel_d = cmd.release_select;
					len_d = new_len;
					rx_pos_d = '0;
					tx_pos_d = '0;
					done_d = 1'b0;
					if (cmd.assert_select) begin
						sel_d = 1'b1;
					end
					if (new_len == '0) begin
						done_d = 1'b1;
						busy_d = 1'b0;
						if (cmd.release_select) begin
							sel_d = 1'b0;
						end
					end else begin
						busy_d = 1'b1;
					end
				end
			end
			spims_pkg::KIND_RX: begin
				if (busy_q) begin
					if (rx_pos_q >= PW'(skip_q) && off < PW'(take_q)) begin
						res.rx_valid = 1'b1;
						res.rx_offset = off[15:0];
						res.rx_data = cmd.rx_byte;
					end
					rx_pos_d = rx_inc;
					if (rx_inc >= len_q) begin
						done_d = 1'b1;
						busy_d = 1'b0;
						if (rel_q) begin
							sel_d = 1'b0;
						end
					end
				end
			end
			spims_pkg::KIND_TXE: begin
				if (busy_q && tx_pos_q < len_q) begin
					res.tx_valid = 1'b1;
					re = accept && (tl_q != '0);
					tx_pos_d = tx_pos_q + PW'(1);
				end
			end
			default: begin
			end
		endcase

		xfer = (rx_pos_d < tx_pos_d) ? rx_pos_d : tx_pos_d;
		res.transferred_count = (xfer > PW'(16'hFFFF)) ? 16'hFFFF : xfer[15:0];
		res.message_done = done_d;
		res.select_active = sel_d;
		res.busy_res = busy_d;
	end

	spims_ram #(
		.WIDTH(8),
		.DEPTH(TX_DEPTH)
	) u_tx_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(cmd.tx_byte),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		res_out = res_s1;
		res_out.tx_data = mem_s1 ? rdata : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_pos_q <= '0;
			tx_pos_q <= '0;
			len_q <= '0;
			skip_q <= '0;
			take_q <= '0;
			tl_q <= '0;
			rel_q <= 1'b0;
			sel_q <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			v_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				rx_pos_q <= rx_pos_d;
				tx_pos_q <= tx_pos_d;
				len_q <= len_d;
				skip_q <= skip_d;
				take_q <= take_d;
				tl_q <= tl_d;
				rel_q <= rel_d;
				sel_q <= sel_d;
				busy_q <= busy_d;
				done_q <= done_d;
			end
			if (cmd_ready) begin
				v_s1 <= accept;
			end
			if (adv) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
			mem_s1 <= re;
		end
		if (adv) begin
			rsp_q <= res_out;
		end
	end

	a_busy_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q))
		else $error("message both busy and done");

	a_rx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rx_pos_q < len_q))
		else $error("receive position past message length while busy");

	a_tx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tx_pos_q <= len_q)
		else $error("transmit position past message length");

	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.tx_valid) |-> (rsp.tx_data == 8'h00))
		else $error("transmit data without transmit valid");

endmodule

### sim/spi_master_message_sequencer_tb.sv
// Self-checking testbench for the SPI master message sequencer, with directed and random items.
`timescale 1ns / 100ps

module spi_master_message_sequencer_tb;

	localparam int TX_DEPTH = spims_pkg::TX_DEPTH_DEFAULT;
	localparam logic [2:0] KIND_LAST = 3'd7;
	localparam int TAIL_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	spims_pkg::cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	spims_pkg::rsp_t rsp;

	logic send_idle = 1'b1;
	logic rsp_idle = 1'b1;
	int unsigned hold_cycles = 0;
	int unsigned items_sent = 0;
	int unsigned fail_count = 0;
	spims_pkg::rsp_t due_rsp[$];

	// Sequencer state as seen by the scoreboard.
	logic [7:0]  tx_bytes [TX_DEPTH];
	logic [16:0] rx_count = '0;
	logic [16:0] tx_count = '0;
	logic [16:0] frame_total = '0;
	logic [15:0] skip_len = '0;
	logic [15:0] take_len = '0;
	logic [8:0]  send_len = '0;
	logic        release_at_end = 1'b0;
	logic        cs_level = 1'b0;
	logic        msg_busy = 1'b0;
	logic        msg_done = 1'b0;

	spi_master_message_sequencer #(.TX_DEPTH(TX_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	function automatic void close_message();
		msg_done = 1'b1;
		msg_busy = 1'b0;
		if (release_at_end) begin
			cs_level = 1'b0;
		end
	endfunction

	function automatic spims_pkg::rsp_t sequence_step(spims_pkg::cmd_t c);
		spims_pkg::rsp_t r;
		logic [8:0] len;
		logic [8:0] idx;
		logic [16:0] rx_need;
		logic [16:0] pos;
		logic [16:0] moved;
		r = '0;
		case (c.kind)
		spims_pkg::KIND_LOAD: begin
			tx_bytes[c.tx_index] = c.tx_byte;
		end
		spims_pkg::KIND_START: begin
			if (!msg_busy) begin
				len = (c.tx_length > TX_DEPTH) ? 9'(TX_DEPTH) : c.tx_length;
				send_len = len;
				skip_len = c.skip_count;
				take_len = c.take_count;
				release_at_end = c.release_select;
				rx_need = {1'b0, c.skip_count} + {1'b0, c.take_count};
				frame_total = ({8'd0, len} > rx_need) ? {8'd0, len} : rx_need;
				rx_count = '0;
				tx_count = '0;
				msg_done = 1'b0;
				if (c.assert_select) begin
					cs_level = 1'b1;
				end
				if (frame_total == '0) begin
					close_message();
				end else begin
					msg_busy = 1'b1;
				end
			end
		end
		spims_pkg::KIND_RX: begin
			if (msg_busy) begin
				if (rx_count >= skip_len && rx_count - skip_len < take_len) begin
					pos = rx_count - skip_len;
					r.rx_valid = 1'b1;
					r.rx_offset = pos[15:0];
					r.rx_data = c.rx_byte;
				end
				rx_count++;
				if (rx_count >= frame_total) begin
					close_message();
				end
			end
		end
		spims_pkg::KIND_TXE: begin
			if (msg_busy && tx_count < frame_total) begin
				r.tx_valid = 1'b1;
				if (send_len != '0) begin
					idx = (tx_count < send_len) ? tx_count[8:0] : send_len - 9'd1;
					r.tx_data = tx_bytes[idx[7:0]];
				end
				tx_count++;
			end
		end
		default: begin
		end
		endcase
		moved = (rx_count < tx_count) ? rx_count : tx_count;
		r.transferred_count = moved[16] ? 16'hffff : moved[15:0];
		r.message_done = msg_done;
		r.select_active = cs_level;
		r.busy_res = msg_busy;
		return r;
	endfunction

	function automatic spims_pkg::cmd_t any_cmd(logic [2:0] kind);
		spims_pkg::cmd_t c;
		logic [95:0] bits;
		bits = {$urandom, $urandom, $urandom};
		c = bits[$bits(spims_pkg::cmd_t)-1:0];
		c.kind = kind;
		return c;
	endfunction

	function automatic spims_pkg::cmd_t start_cmd(logic [8:0] len, logic [15:0] skip,
			logic [15:0] take, logic assert_cs, logic release_cs);
		spims_pkg::cmd_t c;
		c = any_cmd(spims_pkg::KIND_START);
		c.tx_length = len;
		c.skip_count = skip;
		c.take_count = take;
		c.assert_select = assert_cs;
		c.release_select = release_cs;
		return c;
	endfunction

	function automatic spims_pkg::cmd_t noise_cmd();
		case ($urandom_range(0, 4))
		0: return any_cmd(spims_pkg::KIND_LOAD);
		1: return any_cmd(spims_pkg::KIND_RX);
		2: return any_cmd(spims_pkg::KIND_TXE);
		3: return any_cmd(spims_pkg::KIND_ERROR);
		default: return any_cmd(3'($urandom_range(spims_pkg::KIND_ERROR + 1, KIND_LAST)));
		endcase
	endfunction

	task automatic send_item(input spims_pkg::cmd_t c);
		int unsigned gap;
		gap = send_idle ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		due_rsp.push_back(sequence_step(c));
		items_sent++;
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (due_rsp.size() != 0);
	endtask

	// One message with random lengths, fed with frame events and some noise until it completes.
	task automatic random_message();
		spims_pkg::cmd_t c;
		int unsigned pick;
		c = any_cmd(spims_pkg::KIND_START);
		c.tx_length = ($urandom_range(0, 15) == 0) ? 9'($urandom_range(0, 511))
			: 9'($urandom_range(0, 12));
		c.skip_count = 16'($urandom_range(0, 5));
		c.take_count = ($urandom_range(0, 31) == 0) ? 16'($urandom_range(0, 200))
			: 16'($urandom_range(0, 10));
		send_item(c);
		while (msg_busy) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_item(any_cmd(spims_pkg::KIND_RX));
			end else if (pick < 85) begin
				send_item(any_cmd(spims_pkg::KIND_TXE));
			end else if (pick < 95) begin
				send_item(noise_cmd());
			end else begin
				send_item(any_cmd(spims_pkg::KIND_START));
			end
		end
	endtask

	task automatic test_directed();
		spims_pkg::cmd_t c;
		c = any_cmd(spims_pkg::KIND_LOAD);
		c.tx_index = '1;
		c.tx_byte = '1;
		send_item(c);
		c = any_cmd(spims_pkg::KIND_LOAD);
		c.tx_index = 8'd0;
		c.tx_byte = 8'd0;
		send_item(c);
		c = any_cmd(spims_pkg::KIND_LOAD);
		c.tx_index = 8'd1;
		c.tx_byte = 8'h5a;
		send_item(c);
		c = any_cmd(spims_pkg::KIND_LOAD);
		c.tx_index = 8'd2;
		c.tx_byte = 8'ha5;
		send_item(c);
		send_item(any_cmd(spims_pkg::KIND_RX));
		send_item(any_cmd(spims_pkg::KIND_TXE));
		send_item(any_cmd(spims_pkg::KIND_ERROR));
		for (int k = spims_pkg::KIND_ERROR + 1; k <= KIND_LAST; k++) begin
			send_item(any_cmd(3'(k)));
		end
		// Empty messages complete on the start item itself.
		send_item(start_cmd(9'd0, 16'd0, 16'd0, 1'b1, 1'b0));
		send_item(start_cmd(9'd0, 16'd0, 16'd0, 1'b0, 1'b1));
		// With nothing to send, a zero byte goes out.
		send_item(start_cmd(9'd0, 16'd1, 16'd1, 1'b1, 1'b1));
		send_item(any_cmd(spims_pkg::KIND_TXE));
		send_item(start_cmd('1, '1, '1, 1'b1, 1'b1));
		c = any_cmd(spims_pkg::KIND_RX);
		c.rx_byte = '1;
		send_item(c);
		send_item(any_cmd(spims_pkg::KIND_ERROR));
		c = any_cmd(spims_pkg::KIND_RX);
		c.rx_byte = 8'd0;
		send_item(c);
		// The last buffered byte repeats, and a transmit-empty past the end is ignored.
		send_item(start_cmd(9'd3, 16'd2, 16'd3, 1'b1, 1'b0));
		repeat (6) send_item(any_cmd(spims_pkg::KIND_TXE));
		repeat (5) send_item(any_cmd(spims_pkg::KIND_RX));
	endtask

	task automatic test_fill_buffer();
		spims_pkg::cmd_t c;
		logic [7:0] base;
		logic [7:0] stride;
		base = 8'($urandom);
		stride = 8'($urandom) | 8'd1;
		for (int i = 0; i < TX_DEPTH; i++) begin
			c = any_cmd(spims_pkg::KIND_LOAD);
			c.tx_index = 8'(base + i * stride);
			send_item(c);
		end
	endtask

	task automatic test_backpressure();
		int unsigned first;
		send_idle = 1'b0;
		rsp_idle = 1'b0;
		hold_cycles = 400;
		first = items_sent;
		while (items_sent - first < 200) random_message();
		wait_drained();
	endtask

	task automatic test_long_message();
		send_idle = 1'b0;
		rsp_idle = 1'b0;
		send_item(start_cmd('1, 16'd1, 16'd299, 1'b1, 1'b1));
		while (msg_busy) begin
			send_item(any_cmd(spims_pkg::KIND_TXE));
			send_item(any_cmd(spims_pkg::KIND_RX));
		end
		wait_drained();
	endtask

	task automatic test_random();
		int unsigned first;
		first = items_sent;
		while (items_sent - first < 900) begin
			send_idle = $urandom_range(0, 3) != 0;
			rsp_idle = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) send_item(noise_cmd());
			end
			random_message();
		end
	endtask

	initial begin : result_sink
		int unsigned stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				rsp_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			stall = rsp_idle ? $urandom_range(0, 16) : 0;
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (rsp_valid !== 1'b1) @(posedge clk);
		end
	end

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		spims_pkg::rsp_t want;
		if (rsp_valid === 1'b1 && rsp_ready) begin
			if (due_rsp.size() == 0) begin
				$display("%0t: result expected none, got %h", $time, rsp);
				fail_count++;
			end else begin
				want = due_rsp.pop_front();
				check_field("tx_valid", 16'(want.tx_valid), 16'(rsp.tx_valid));
				check_field("tx_data", 16'(want.tx_data), 16'(rsp.tx_data));
				check_field("rx_valid", 16'(want.rx_valid), 16'(rsp.rx_valid));
				check_field("rx_offset", want.rx_offset, rsp.rx_offset);
				check_field("rx_data", 16'(want.rx_data), 16'(rsp.rx_data));
				check_field("transferred_count", want.transferred_count,
					rsp.transferred_count);
				check_field("message_done", 16'(want.message_done), 16'(rsp.message_done));
				check_field("select_active", 16'(want.select_active), 16'(rsp.select_active));
				check_field("busy_res", 16'(want.busy_res), 16'(rsp.busy_res));
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_buffer();
		test_backpressure();
		test_long_message();
		test_random();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
